@@ design/bprm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the biaxial plastic return map.
// Used by every module of the block; depends on nothing.
package bprm_pkg;

   localparam int DW    = 32;
   localparam int FRAC  = 16;
   localparam int CFG_W = DW - 1;
   localparam int PW    = 2 * DW;
   localparam int MD_CW = $clog2(PW);
   localparam int SQ_CW = $clog2(DW);

   typedef logic signed [DW-1:0] val_type;
   typedef logic [DW-1:0]        mag_type;
   typedef logic [PW-1:0]        wide_type;

   localparam val_type VMAX = {1'b0, {(DW-1){1'b1}}};
   localparam val_type VMIN = {1'b1, {(DW-1){1'b0}}};
   localparam val_type ONE  = val_type'(64'd1 << FRAC);

   typedef enum logic [1:0] {
      REQ_COMPUTE = 2'd0,
      REQ_COMMIT  = 2'd1,
      REQ_REVERT  = 2'd2,
      REQ_RESTART = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_YOUNG  = 3'd0,
      CSR_YIELD  = 3'd1,
      CSR_ISO    = 3'd2,
      CSR_KIN    = 3'd3,
      CSR_INIT_X = 3'd4,
      CSR_INIT_Y = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      STEP_S0, STEP_S1, STEP_SQ0, STEP_SQ1, STEP_SQRT, STEP_HARD,
      STEP_DLAM, STEP_AA, STEP_BT, STEP_BB, STEP_T0, STEP_T1,
      STEP_DN0, STEP_DN1, STEP_ED0, STEP_ED1, STEP_HD0, STEP_HD1,
      STEP_KXX, STEP_KYY, STEP_KXY
   } step_type;

   typedef enum logic [1:0] {
      MD_IDLE, MD_MUL, MD_DIV, MD_FIN
   } md_phase_type;

   typedef struct packed {
      logic    start;
      logic    raw;
      val_type a;
      val_type b;
      val_type c;
   } md_req_type;

   typedef struct packed {
      logic     done;
      val_type  value;
      wide_type prod;
   } md_rsp_type;

   typedef struct packed {
      logic     start;
      wide_type rad;
   } sq_req_type;

   typedef struct packed {
      logic    done;
      val_type root;
   } sq_rsp_type;

   function automatic val_type sadd(input val_type a, input val_type b);
      logic signed [DW:0] s;
      s = {a[DW-1], a} + {b[DW-1], b};
      if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
      return s[DW-1:0];
   endfunction

   function automatic val_type ssub(input val_type a, input val_type b);
      logic signed [DW:0] s;
      s = {a[DW-1], a} - {b[DW-1], b};
      if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
      return s[DW-1:0];
   endfunction

   function automatic mag_type magv(input val_type a);
      return a[DW-1] ? mag_type'(-a) : mag_type'(a);
   endfunction

endpackage

@@ design/bprm_muldiv.sv @@
`timescale 1ns / 1ps
// Shared a*b/c unit: shift-add multiply then, unless raw is set, restoring divide, saturated result.
// Depends on bprm_pkg.
module bprm_muldiv
   import bprm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  md_req_type md_req,
   output md_rsp_type md_rsp
);

   md_phase_type         phase_ff, phase_in;
   logic [MD_CW-1:0]     cnt_ff;
   wide_type             mcand_ff, prod_ff, quot_ff;
   mag_type              mplier_ff, div_ff, rem_ff, lim;
   logic                 neg_ff, zero_ff, czero_ff, sab_ff, raw_ff, done_ff, sat;
   val_type              value_ff;
   logic [DW:0]          rem_sh;
   logic                 ge;

   assign rem_sh = {rem_ff, prod_ff[PW-1]};
   assign ge     = rem_sh >= {1'b0, div_ff};
   assign lim    = neg_ff ? mag_type'(VMIN) : mag_type'(VMAX);
   assign sat    = (|quot_ff[PW-1:DW]) || (quot_ff[DW-1:0] > lim);

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= MD_IDLE;
      else       phase_ff <= phase_in;
   end

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         MD_IDLE: if (md_req.start) phase_in = MD_MUL;
         MD_MUL:  if (cnt_ff == '0) phase_in = raw_ff ? MD_FIN : MD_DIV;
         MD_DIV:  if (cnt_ff == '0) phase_in = MD_FIN;
         MD_FIN:  phase_in = MD_IDLE;
         default: phase_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else       done_ff <= (phase_ff == MD_FIN);
   end

   always_ff @(posedge clock) begin
      case (phase_ff)
         MD_IDLE: begin
            mcand_ff  <= wide_type'(magv(md_req.a));
            mplier_ff <= magv(md_req.b);
            div_ff    <= magv(md_req.c);
            prod_ff   <= '0;
            neg_ff    <= md_req.a[DW-1] ^ md_req.b[DW-1] ^ md_req.c[DW-1];
            sab_ff    <= md_req.a[DW-1] ^ md_req.b[DW-1];
            zero_ff   <= (md_req.a == '0) || (md_req.b == '0);
            czero_ff  <= (md_req.c == '0);
            raw_ff    <= md_req.raw;
            cnt_ff    <= MD_CW'(DW - 1);
         end
         MD_MUL: begin
            if (mplier_ff[0]) prod_ff <= prod_ff + mcand_ff;
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
            cnt_ff    <= (cnt_ff == '0) ? MD_CW'(PW - 1) : cnt_ff - 1'b1;
            rem_ff    <= '0;
            quot_ff   <= '0;
         end
         MD_DIV: begin
            rem_ff  <= ge ? mag_type'(rem_sh - {1'b0, div_ff}) : rem_sh[DW-1:0];
            quot_ff <= {quot_ff[PW-2:0], ge};
            prod_ff <= prod_ff << 1;
            cnt_ff  <= cnt_ff - 1'b1;
         end
         default: begin
            if (zero_ff)       value_ff <= '0;
            else if (czero_ff) value_ff <= sab_ff ? VMIN : VMAX;
            else if (sat)      value_ff <= neg_ff ? VMIN : VMAX;
            else if (neg_ff)   value_ff <= val_type'(-quot_ff[DW-1:0]);
            else               value_ff <= val_type'(quot_ff[DW-1:0]);
         end
      endcase
   end

   assign md_rsp.done  = done_ff;
   assign md_rsp.value = value_ff;
   assign md_rsp.prod  = prod_ff;

endmodule

@@ design/bprm_sqrt.sv @@
`timescale 1ns / 1ps
// Digit-by-digit integer square root of a double-width radicand, saturated.
// Depends on bprm_pkg.
module bprm_sqrt
   import bprm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  sq_req_type sq_req,
   output sq_rsp_type sq_rsp
);

   logic             busy_ff, done_ff;
   logic [SQ_CW-1:0] cnt_ff;
   wide_type         rad_ff;
   logic [DW+1:0]    rem_ff;
   mag_type          root_ff;
   logic [DW+3:0]    rem_sh, test;
   logic             ge;

   assign rem_sh = {rem_ff, rad_ff[PW-1:PW-2]};
   assign test   = {2'b00, root_ff, 2'b01};
   assign ge     = rem_sh >= test;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (sq_req.start)          busy_ff <= 1'b1;
         else if (cnt_ff == '0)     busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff) begin
         rad_ff  <= sq_req.rad;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= SQ_CW'(DW - 1);
      end else begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= ge ? (DW+2)'(rem_sh - test) : rem_sh[DW+1:0];
         root_ff <= {root_ff[DW-2:0], ge};
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   assign sq_rsp.done = done_ff;
   assign sq_rsp.root = root_ff[DW-1] ? VMAX : val_type'(root_ff);

endmodule

@@ design/biaxial_plastic_return_map.sv @@
`timescale 1ns / 1ps
// Biaxial plastic return map top level: sequencer, material state and result register.
// Depends on bprm_pkg, bprm_muldiv and bprm_sqrt.
//
// A compute request runs as a sequence of steps on one shared a*b/c unit, the two
// squaring steps skipping the divide, and one square root unit. An elastic step ends
// after the hardening step, a plastic step runs on through the stiffness steps.
// Commit, revert and restart requests skip the steps and go straight to the result.
// The block takes one request at a time; req_stall is high while it works.
// The result waits in an output register, so the next request may be taken
// before the previous result leaves.
module biaxial_plastic_return_map
   import bprm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic signed [DW-1:0] req_def_x,
   input  logic signed [DW-1:0] req_def_y,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [DW-1:0] rsp_stress_x,
   output logic signed [DW-1:0] rsp_stress_y,
   output logic signed [DW-1:0] rsp_stiff_xx,
   output logic signed [DW-1:0] rsp_stiff_yy,
   output logic signed [DW-1:0] rsp_stiff_xy,
   output logic              rsp_yielded,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [DW-1:0]     csr_data
);

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [CFG_W-1:0] e_ff, sigy_ff, hi_ff, hk_ff;
   val_type idx_ff, idy_ff;
   val_type cep0_ff, cep1_ff, tep0_ff, tep1_ff, cq0_ff, cq1_ff, tq0_ff, tq1_ff;
   val_type cal_ff, tal_ff;

   val_type de0_ff, de1_ff, h_ff, s0_ff, s1_ff, xi0_ff, xi1_ff, nrm_ff, f_ff;
   val_type dlam_ff, a_ff, tmp_ff, b_ff, t0_ff, t1_ff, dn0_ff, dn1_ff;
   val_type r0_ff, r1_ff, kxx_ff, kyy_ff, kxy_ff;
   logic    yl_ff;
   wide_type acc_ff;

   val_type o_sx_ff, o_sy_ff, o_kxx_ff, o_kyy_ff, o_kxy_ff;
   logic    o_yl_ff;

   val_type ev, hkv, hiv, eb, ba, sy, fv, res, rin;
   logic    req_acc, load_out, elastic;
   req_kind_type kind;
   md_req_type md_req;
   md_rsp_type md_rsp;
   sq_req_type sq_req;
   sq_rsp_type sq_rsp;

   bprm_muldiv u_muldiv (.clock(clock), .reset(reset), .md_req(md_req), .md_rsp(md_rsp));
   bprm_sqrt   u_sqrt   (.clock(clock), .reset(reset), .sq_req(sq_req), .sq_rsp(sq_rsp));

   assign ev   = val_type'({1'b0, e_ff});
   assign hkv  = val_type'({1'b0, hk_ff});
   assign hiv  = val_type'({1'b0, hi_ff});
   assign eb   = ssub(ev, b_ff);
   assign ba   = ssub(b_ff, a_ff);
   assign res  = md_rsp.value;
   assign sy   = sadd(val_type'({1'b0, sigy_ff}), res);
   assign fv   = ssub(nrm_ff, sy);
   assign elastic = fv[DW-1] || (nrm_ff == '0);
   assign kind = req_kind_type'(req_type);
   assign rin  = sadd(eb, res);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign load_out  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      md_req.start = (state_ff == ST_ISSUE) && (step_ff != STEP_SQRT);
      md_req.raw   = 1'b0;
      md_req.a     = ev;
      md_req.b     = ev;
      md_req.c     = ONE;
      unique case (step_ff)
         STEP_S0:   md_req.b = de0_ff;
         STEP_S1:   md_req.b = de1_ff;
         STEP_SQ0:  begin md_req.raw = 1'b1; md_req.a = xi0_ff; md_req.b = xi0_ff; end
         STEP_SQ1:  begin md_req.raw = 1'b1; md_req.a = xi1_ff; md_req.b = xi1_ff; end
         STEP_SQRT: md_req.b = ev;
         STEP_HARD: begin md_req.a = cal_ff; md_req.b = hiv; end
         STEP_DLAM: begin md_req.a = f_ff; md_req.b = ONE; md_req.c = h_ff; end
         STEP_AA:   md_req.c = h_ff;
         STEP_BT:   begin md_req.b = dlam_ff; md_req.c = nrm_ff; end
         STEP_BB:   md_req.b = tmp_ff;
         STEP_T0:   begin md_req.a = ba; md_req.b = xi0_ff; md_req.c = nrm_ff; end
         STEP_T1:   begin md_req.a = ba; md_req.b = xi1_ff; md_req.c = nrm_ff; end
         STEP_DN0:  begin md_req.a = xi0_ff; md_req.b = dlam_ff; md_req.c = nrm_ff; end
         STEP_DN1:  begin md_req.a = xi1_ff; md_req.b = dlam_ff; md_req.c = nrm_ff; end
         STEP_ED0:  md_req.b = dn0_ff;
         STEP_ED1:  md_req.b = dn1_ff;
         STEP_HD0:  begin md_req.a = hkv; md_req.b = dn0_ff; end
         STEP_HD1:  begin md_req.a = hkv; md_req.b = dn1_ff; end
         STEP_KXX:  begin md_req.a = t0_ff; md_req.b = xi0_ff; md_req.c = nrm_ff; end
         STEP_KYY:  begin md_req.a = t1_ff; md_req.b = xi1_ff; md_req.c = nrm_ff; end
         STEP_KXY:  begin md_req.a = t0_ff; md_req.b = xi1_ff; md_req.c = nrm_ff; end
         default:   md_req.b = ev;
      endcase
      sq_req.start = (state_ff == ST_ISSUE) && (step_ff == STEP_SQRT);
      sq_req.rad   = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_S0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               step_in  = STEP_S0;
               state_in = (kind == REQ_COMPUTE) ? ST_ISSUE : ST_DONE;
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (step_ff == STEP_SQRT) begin
               if (sq_rsp.done) begin
                  step_in  = STEP_HARD;
                  state_in = ST_ISSUE;
               end
            end else if (md_rsp.done) begin
               if ((step_ff == STEP_HARD && elastic) || step_ff == STEP_KXY) begin
                  state_in = ST_DONE;
               end else begin
                  step_in  = step_type'(step_ff + 1'b1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_DONE: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff    <= '0;
         sigy_ff <= '0;
         hi_ff   <= '0;
         hk_ff   <= '0;
         idx_ff  <= '0;
         idy_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_YOUNG:  e_ff    <= csr_data[CFG_W-1:0];
            CSR_YIELD:  sigy_ff <= csr_data[CFG_W-1:0];
            CSR_ISO:    hi_ff   <= csr_data[CFG_W-1:0];
            CSR_KIN:    hk_ff   <= csr_data[CFG_W-1:0];
            CSR_INIT_X: idx_ff  <= val_type'(csr_data);
            CSR_INIT_Y: idy_ff  <= val_type'(csr_data);
            default:    idx_ff  <= idx_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cep0_ff <= '0; cep1_ff <= '0; tep0_ff <= '0; tep1_ff <= '0;
         cq0_ff  <= '0; cq1_ff  <= '0; tq0_ff  <= '0; tq1_ff  <= '0;
         cal_ff  <= '0; tal_ff  <= '0;
      end else if (req_acc) begin
         unique case (kind)
            REQ_COMMIT: begin
               cep0_ff <= tep0_ff; cep1_ff <= tep1_ff;
               cq0_ff  <= tq0_ff;  cq1_ff  <= tq1_ff;
               cal_ff  <= tal_ff;
            end
            REQ_REVERT: begin
               tep0_ff <= cep0_ff; tep1_ff <= cep1_ff;
               tq0_ff  <= cq0_ff;  tq1_ff  <= cq1_ff;
               tal_ff  <= cal_ff;
            end
            REQ_RESTART: begin
               cep0_ff <= '0; cep1_ff <= '0; tep0_ff <= '0; tep1_ff <= '0;
               cq0_ff  <= '0; cq1_ff  <= '0; tq0_ff  <= '0; tq1_ff  <= '0;
               cal_ff  <= '0; tal_ff  <= '0;
            end
            default: tal_ff <= tal_ff;
         endcase
      end else if (state_ff == ST_WAIT && md_rsp.done) begin
         if (step_ff == STEP_HARD && elastic) begin
            tep0_ff <= cep0_ff; tep1_ff <= cep1_ff;
            tq0_ff  <= cq0_ff;  tq1_ff  <= cq1_ff;
            tal_ff  <= cal_ff;
         end else if (step_ff == STEP_KXY) begin
            tep0_ff <= sadd(cep0_ff, dn0_ff);
            tep1_ff <= sadd(cep1_ff, dn1_ff);
            tal_ff  <= sadd(cal_ff, dlam_ff);
         end else if (step_ff == STEP_HD0) begin
            tq0_ff  <= sadd(cq0_ff, res);
         end else if (step_ff == STEP_HD1) begin
            tq1_ff  <= sadd(cq1_ff, res);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         de0_ff <= ssub(ssub(req_def_x, idx_ff), cep0_ff);
         de1_ff <= ssub(ssub(req_def_y, idy_ff), cep1_ff);
         h_ff   <= sadd(sadd(ev, hkv), hiv);
         r0_ff  <= '0; r1_ff <= '0; kxx_ff <= '0; kyy_ff <= '0; kxy_ff <= '0;
         yl_ff  <= 1'b0;
      end
      if (state_ff == ST_WAIT && step_ff == STEP_SQRT && sq_rsp.done) nrm_ff <= sq_rsp.root;
      if (state_ff == ST_WAIT && md_rsp.done) begin
         case (step_ff)
            STEP_S0:  begin s0_ff <= res; xi0_ff <= ssub(res, cq0_ff); end
            STEP_S1:  begin s1_ff <= res; xi1_ff <= ssub(res, cq1_ff); end
            STEP_SQ0: acc_ff <= md_rsp.prod;
            STEP_SQ1: acc_ff <= acc_ff + md_rsp.prod;
            STEP_HARD: begin
               f_ff <= fv;
               if (elastic) begin
                  r0_ff <= s0_ff; r1_ff <= s1_ff;
                  kxx_ff <= ev; kyy_ff <= ev; kxy_ff <= '0; yl_ff <= 1'b0;
               end
            end
            STEP_DLAM: dlam_ff <= res;
            STEP_AA:   a_ff    <= res;
            STEP_BT:   tmp_ff  <= res;
            STEP_BB:   b_ff    <= res;
            STEP_T0:   t0_ff   <= res;
            STEP_T1:   t1_ff   <= res;
            STEP_DN0:  dn0_ff  <= res;
            STEP_DN1:  dn1_ff  <= res;
            STEP_ED0:  r0_ff   <= ssub(s0_ff, res);
            STEP_ED1:  r1_ff   <= ssub(s1_ff, res);
            STEP_KXX:  kxx_ff  <= rin;
            STEP_KYY:  kyy_ff  <= rin;
            STEP_KXY:  begin kxy_ff <= res; yl_ff <= 1'b1; end
            default:   acc_ff  <= acc_ff;
         endcase
      end
      if (load_out) begin
         o_sx_ff  <= r0_ff;
         o_sy_ff  <= r1_ff;
         o_kxx_ff <= kxx_ff;
         o_kyy_ff <= kyy_ff;
         o_kxy_ff <= kxy_ff;
         o_yl_ff  <= yl_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_stress_x = o_sx_ff;
   assign rsp_stress_y = o_sy_ff;
   assign rsp_stiff_xx = o_kxx_ff;
   assign rsp_stiff_yy = o_kyy_ff;
   assign rsp_stiff_xy = o_kxy_ff;
   assign rsp_yielded  = o_yl_ff;

`ifndef SYNTHESIS
   a_md_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> (state_ff == ST_WAIT) && (step_ff != STEP_SQRT))
      else $error("multiply-divide result outside its wait step");
   a_sq_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sq_rsp.done |-> (state_ff == ST_WAIT) && (step_ff == STEP_SQRT))
      else $error("square root result outside its wait step");
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid && (state_ff == ST_IDLE))
      else $error("result load did not present a response");
`endif

endmodule
